// ===== rtl/core/rcfld_pkg.sv =====
// Package with shared types and constants for the receiver frame link decoder.
`default_nettype none
package rcfld_pkg;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_RSSI_LIMIT     = 3'd0;
    localparam cfg_idx_t CFG_SW_LOW_LIMIT   = 3'd1;
    localparam cfg_idx_t CFG_SW_MID_LOW     = 3'd2;
    localparam cfg_idx_t CFG_SW_MID_HIGH    = 3'd3;
    localparam cfg_idx_t CFG_SW_HIGH_LIMIT  = 3'd4;

    localparam logic [7:0] END_BYTE       = 8'h7F;
    localparam logic [7:0] RSSI_CEILING   = 8'd245;
    localparam int         RSSI_INDEX     = 8;

    localparam logic [7:0] RSSI_LIMIT_RST = 8'd40;
    localparam logic [7:0] SW_LOW_RST     = 8'hC0;
    localparam logic [7:0] SW_MID_LOW_RST = 8'hEC;
    localparam logic [7:0] SW_MID_HIGH_RST = 8'h14;
    localparam logic [7:0] SW_HIGH_RST    = 8'h40;

    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic signed [7:0] low;
        logic signed [7:0] mid_low;
        logic signed [7:0] mid_high;
        logic signed [7:0] high;
    } sw_limits_t;

endpackage
`default_nettype wire

// ===== rtl/core/rc_frame_link_decoder.sv =====
// Top level: frame assembly, link tracking and channel decode of receiver bytes.
// Output: the result is registered at the edge that takes the end byte out of the input
// register, and m_tvalid rises with that result register.
// Throughput: one byte per cycle; the input stage stalls only while a result waits untaken.
// Reset: byte count, link flag, valids and limit registers clear to defaults;
// frame byte storage is not reset.
`default_nettype none
module rc_frame_link_decoder #(
    parameter int FRAME_LEN = 9
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire rcfld_pkg::cfg_idx_t               cfg_index,
    input  wire logic [7:0]                        cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: [7:0] rx_byte
    input  wire logic [7:0]                        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: [0] link_up, [8:1] axis_a, [16:9] axis_b, [24:17] axis_c, [32:25] axis_d,
    //          [33] switch_a, [34] switch_b, [36:35] switch_c, [38:37] switch_d, [39] zero
    output logic [rcfld_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: [0] event_res
    output logic                                   m_tuser
);
    import rcfld_pkg::*;

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_LEN);

    logic [7:0]            rssi_limit_reg;
    sw_limits_t            sw_lim_reg;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic [7:0]            frame_reg [FRAME_LEN];
    logic [CNT_W-1:0]      count_reg;
    logic                  link_reg;

    logic                  out_valid_reg;
    logic                  out_event_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  go;
    logic                  is_end;
    logic                  full;
    logic                  lose;
    logic                  acquire;
    logic                  emit_values;
    logic                  emit;
    logic                  link_next;
    logic [OUT_DATA_W-1:0] data_next;
    logic [7:0]            rssi_u;

    function automatic logic [1:0] classify(input logic [7:0] raw, input logic three,
                                            input sw_limits_t lim);
        logic signed [7:0] v;
        logic [1:0]        pos;
        v = $signed(raw);
        if (v <= lim.low)
            pos = 2'd0;
        else if (three && v <= lim.mid_high && v >= lim.mid_low)
            pos = 2'd1;
        else if (three && v >= lim.high)
            pos = 2'd2;
        else
            pos = 2'd1;
        return pos;
    endfunction

    assign go       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;

    assign is_end  = (in_byte_reg == END_BYTE);
    assign full    = (count_reg == FULL_CNT);
    assign rssi_u  = frame_reg[RSSI_INDEX];
    assign lose    = link_reg && ($signed({rssi_u[7], rssi_u}) < $signed({1'b0, rssi_limit_reg}));
    assign acquire = !link_reg && (rssi_u > rssi_limit_reg) && (rssi_u < RSSI_CEILING);

    always_comb
    begin
        emit_values = 1'b0;
        link_next   = link_reg;
        if (is_end && full)
        begin
            if (lose)
                link_next = 1'b0;
            else if (link_reg || acquire)
            begin
                link_next   = 1'b1;
                emit_values = 1'b1;
            end
        end
    end

    assign emit = is_end && full && (lose || emit_values);

    always_comb
    begin
        data_next = '0;
        if (emit_values)
        begin
            data_next[0]     = 1'b1;
            data_next[8:1]   = frame_reg[0];
            data_next[16:9]  = frame_reg[1];
            data_next[24:17] = frame_reg[2];
            data_next[32:25] = frame_reg[3];
            data_next[33]    = (classify(frame_reg[4], 1'b0, sw_lim_reg) != 2'd0);
            data_next[34]    = (classify(frame_reg[5], 1'b0, sw_lim_reg) != 2'd0);
            data_next[36:35] = classify(frame_reg[6], 1'b1, sw_lim_reg);
            data_next[38:37] = classify(frame_reg[7], 1'b1, sw_lim_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_limit_reg       <= RSSI_LIMIT_RST;
            sw_lim_reg.low       <= SW_LOW_RST;
            sw_lim_reg.mid_low   <= SW_MID_LOW_RST;
            sw_lim_reg.mid_high  <= SW_MID_HIGH_RST;
            sw_lim_reg.high      <= SW_HIGH_RST;
            in_valid_reg         <= 1'b0;
            count_reg            <= '0;
            link_reg             <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RSSI_LIMIT:    rssi_limit_reg      <= cfg_data;
                    CFG_SW_LOW_LIMIT:  sw_lim_reg.low      <= cfg_data;
                    CFG_SW_MID_LOW:    sw_lim_reg.mid_low  <= cfg_data;
                    CFG_SW_MID_HIGH:   sw_lim_reg.mid_high <= cfg_data;
                    CFG_SW_HIGH_LIMIT: sw_lim_reg.high     <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (go)
            begin
                link_reg <= link_next;
                if (is_end)
                    count_reg <= '0;
                else if (!full)
                    count_reg <= count_reg + 1'b1;
            end
            if (go)
                out_valid_reg <= emit;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (go && !is_end && !full)
            frame_reg[count_reg[IDX_W-1:0]] <= in_byte_reg;
        if (go && emit)
        begin
            out_event_reg <= lose;
            out_data_reg  <= data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_event_reg;

endmodule
`default_nettype wire
